### rtl/lacm_pkg.sv
// ----------------------------------------------------------------------------
// lacm_pkg
// Shared widths, limits and register codes for the linear arrangement cost
// block and its channel interfaces.
// ----------------------------------------------------------------------------
package lacm_pkg;

    // Sizing of the site store
    localparam int MAX_SITES   = 128;
    localparam int WEIGHT_BITS = 8;
    localparam int ADDR_W      = $clog2(MAX_SITES);
    localparam int CNT_W       = $clog2(MAX_SITES + 1);

    // Field widths of the words on the channels
    localparam int IDX_W  = 7;
    localparam int WT_W   = 8;
    localparam int SUM_W  = 36;
    localparam int CUT_W  = 22;
    localparam int SPAN_W = 15;

    // Internal arithmetic widths
    localparam int DIST_W  = ADDR_W;
    localparam int WSPAN_W = WEIGHT_BITS + DIST_W;
    localparam int PROD_W  = WSPAN_W + DIST_W;
    localparam int DELTA_W = 18;
    localparam int RUN_W   = 23;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int SITE_W     = 8;
    localparam logic [SITE_W-1:0] SITE_COUNT_RST = 8'd128;

    typedef enum logic [0:0] {
        REG_SITE_COUNT = 1'b0
    } cfg_reg_t;

endpackage : lacm_pkg

### rtl/lacm_if.sv
// ----------------------------------------------------------------------------
// lacm channel interfaces
// Valid/ready channels for matrix entry words and cost result words.
// ----------------------------------------------------------------------------
interface lacm_item_if;
    import lacm_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] row_index;
    logic [IDX_W-1:0] col_index;
    logic [WT_W-1:0]  entry_weight;
    logic             last_entry;

    modport source (
        output valid, row_index, col_index, entry_weight, last_entry,
        input  ready
    );
    modport sink (
        input  valid, row_index, col_index, entry_weight, last_entry,
        output ready
    );
endinterface : lacm_item_if

interface lacm_result_if;
    import lacm_pkg::*;

    logic              valid;
    logic              ready;
    logic [SUM_W-1:0]  squared_span_sum;
    logic [CUT_W-1:0]  max_cut_weight;
    logic [SPAN_W-1:0] max_weighted_span;

    modport source (
        output valid, squared_span_sum, max_cut_weight, max_weighted_span,
        input  ready
    );
    modport sink (
        input  valid, squared_span_sum, max_cut_weight, max_weighted_span,
        output ready
    );
endinterface : lacm_result_if

### rtl/linear_arrangement_cost_metrics_top.sv
// ----------------------------------------------------------------------------
// linear_arrangement_cost_metrics_top
// Layout costs of a site-coupling matrix: squared span sum, cutwidth and
// largest weighted span, built up one matrix entry word at a time.
// ----------------------------------------------------------------------------
// Each entry word is taken in the accept cycle and then runs three sequencer
// steps in which one shared multiplier forms w*d and then w*d*d, while the
// crossing store (one read port, one write port) is read and updated at the
// row and at the column. A word that carries the last mark then runs a prefix
// scan over the crossing store, one store word per cycle, n-1 reads for n
// sites in use, and then loads the result register once it is free. The result
// register stands apart from the input side, so the next matrix may start
// while a result is still waiting to be taken. The store needs no clearing
// pass: a valid bit per word, cleared at once on reset and on each result,
// makes an unwritten word read as zero.
// ----------------------------------------------------------------------------
module linear_arrangement_cost_metrics_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lacm_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [lacm_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [lacm_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    lacm_item_if.sink                       item_in,
    lacm_result_if.source                   result_out
);
    import lacm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_W,
        S_MUL_D,
        S_ACC,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t state_reg;

    // Configuration
    logic [SITE_W-1:0] site_count_reg;
    logic [CNT_W-1:0]  n_act;
    logic              cfg_sel;

    // Latched entry word
    logic [ADDR_W-1:0]      row_reg;
    logic [ADDR_W-1:0]      col_reg;
    logic [WEIGHT_BITS-1:0] wt_reg;
    logic [DIST_W-1:0]      dist_reg;
    logic                   hit_reg;
    logic                   upper_reg;
    logic                   last_reg;

    // Entry decode
    logic                   in_hit;
    logic                   in_upper;
    logic [WEIGHT_BITS-1:0] in_wt;
    logic [IDX_W-1:0]       in_dist;

    // Shared multiplier
    logic [WSPAN_W-1:0] mul_a;
    logic [PROD_W-1:0]  mul_p;
    logic [PROD_W-1:0]  prod_reg;

    // Accumulators
    logic [SUM_W-1:0]  sum_acc_reg;
    logic [SPAN_W-1:0] span_max_reg;
    logic [SUM_W:0]    sum_wide;
    logic [SUM_W-1:0]  sum_sat;

    // Crossing store
    logic signed [DELTA_W-1:0] cut_mem [MAX_SITES];
    logic [MAX_SITES-1:0]      valid_reg;
    logic signed [DELTA_W-1:0] rd_data_reg;
    logic                      rd_valid_reg;
    logic signed [DELTA_W-1:0] rd_word;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      wr_en;
    logic [ADDR_W-1:0]         wr_addr;
    logic signed [DELTA_W-1:0] wr_data;
    logic signed [DELTA_W-1:0] wt_delta;

    // Prefix scan
    logic [CNT_W-1:0]        scan_idx_reg;
    logic                    scan_pend_reg;
    logic                    scan_issue;
    logic signed [RUN_W-1:0] run_cut_reg;
    logic signed [RUN_W-1:0] cut_max_reg;
    logic signed [RUN_W-1:0] run_next;
    logic signed [RUN_W-1:0] cut_max_next;

    // Result register
    logic              out_valid_reg;
    logic [SUM_W-1:0]  out_sum_reg;
    logic [CUT_W-1:0]  out_cut_reg;
    logic [SPAN_W-1:0] out_span_reg;
    logic              emit_go;

    // Configuration register, APB write in the access phase
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[CFG_ADDR_W-1:2] == REG_SITE_COUNT);
    assign prdata  = cfg_sel ? CFG_DATA_W'(site_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            site_count_reg <= SITE_COUNT_RST;
        end
        else if (psel && penable && pwrite && pready && cfg_sel)
        begin
            site_count_reg <= pwdata[SITE_W-1:0];
        end
    end

    // Sites in use, capped at the store depth
    assign n_act = (32'(site_count_reg) > MAX_SITES) ? CNT_W'(MAX_SITES)
                                                      : CNT_W'(site_count_reg);

    // Entry decode at the input
    assign in_wt    = item_in.entry_weight[WEIGHT_BITS-1:0];
    assign in_hit   = (32'(item_in.row_index) < 32'(n_act))
                   && (32'(item_in.col_index) < 32'(n_act))
                   && (in_wt != '0);
    assign in_upper = (item_in.row_index < item_in.col_index);
    assign in_dist  = in_upper ? (item_in.col_index - item_in.row_index)
                               : (item_in.row_index - item_in.col_index);

    assign item_in.ready = (state_reg == S_IDLE);

    // Shared multiplier: w*d first, then (w*d)*d
    assign mul_a = (state_reg == S_MUL_W) ? WSPAN_W'(wt_reg) : prod_reg[WSPAN_W-1:0];
    assign mul_p = PROD_W'(mul_a) * PROD_W'(dist_reg);

    // Saturating add into the squared span sum
    assign sum_wide = {1'b0, sum_acc_reg} + (SUM_W + 1)'(prod_reg);
    assign sum_sat  = (sum_wide > {1'b0, SUM_MAX}) ? SUM_MAX : sum_wide[SUM_W-1:0];

    // Store port steering: row in the first step, column in the second, scan after
    assign rd_word  = rd_valid_reg ? rd_data_reg : '0;
    assign wt_delta = $signed({{(DELTA_W - WEIGHT_BITS){1'b0}}, wt_reg});

    always_comb
    begin
        rd_addr = scan_idx_reg[ADDR_W-1:0];
        wr_en   = 1'b0;
        wr_addr = row_reg;
        wr_data = rd_word + wt_delta;
        unique case (state_reg)
            S_MUL_W:
            begin
                rd_addr = row_reg;
            end
            S_MUL_D:
            begin
                rd_addr = col_reg;
                wr_en   = hit_reg && upper_reg;
                wr_addr = row_reg;
                wr_data = rd_word + wt_delta;
            end
            S_ACC:
            begin
                wr_en   = hit_reg && upper_reg;
                wr_addr = col_reg;
                wr_data = rd_word - wt_delta;
            end
            default:
            begin
                rd_addr = scan_idx_reg[ADDR_W-1:0];
            end
        endcase
    end

    // Scan: read cut words 0 .. n-2, fold one per cycle
    assign scan_issue   = (state_reg == S_SCAN)
                       && (({1'b0, scan_idx_reg} + 1'b1) < {1'b0, n_act});
    assign run_next     = run_cut_reg + RUN_W'(rd_word);
    assign cut_max_next = (run_next > cut_max_reg) ? run_next : cut_max_reg;

    assign emit_go = (state_reg == S_EMIT) && (!out_valid_reg || result_out.ready);

    // Crossing store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cut_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= cut_mem[rd_addr];
    end

    // Sequencer, accumulators and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            wt_reg        <= '0;
            dist_reg      <= '0;
            hit_reg       <= 1'b0;
            upper_reg     <= 1'b0;
            last_reg      <= 1'b0;
            prod_reg      <= '0;
            sum_acc_reg   <= '0;
            span_max_reg  <= '0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            scan_idx_reg  <= '0;
            scan_pend_reg <= 1'b0;
            run_cut_reg   <= '0;
            cut_max_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_sum_reg   <= '0;
            out_cut_reg   <= '0;
            out_span_reg  <= '0;
        end
        else
        begin
            // result word taken and no new one loaded behind it
            if (out_valid_reg && result_out.ready && !emit_go)
            begin
                out_valid_reg <= 1'b0;
            end
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];

            unique case (state_reg)
                S_IDLE:
                begin
                    if (item_in.valid)
                    begin
                        row_reg   <= ADDR_W'(item_in.row_index);
                        col_reg   <= ADDR_W'(item_in.col_index);
                        wt_reg    <= in_wt;
                        dist_reg  <= DIST_W'(in_dist);
                        hit_reg   <= in_hit;
                        upper_reg <= in_upper;
                        last_reg  <= item_in.last_entry;
                        state_reg <= S_MUL_W;
                    end
                end
                S_MUL_W:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_MUL_D;
                end
                S_MUL_D:
                begin
                    // prod_reg still holds w*d here
                    prod_reg <= mul_p;
                    if (hit_reg && upper_reg
                        && (SPAN_W'(prod_reg[WSPAN_W-1:0]) > span_max_reg))
                    begin
                        span_max_reg <= SPAN_W'(prod_reg[WSPAN_W-1:0]);
                    end
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (hit_reg)
                    begin
                        sum_acc_reg <= sum_sat;
                    end
                    if (last_reg)
                    begin
                        scan_idx_reg  <= '0;
                        scan_pend_reg <= 1'b0;
                        run_cut_reg   <= '0;
                        cut_max_reg   <= '0;
                        state_reg     <= S_SCAN;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_SCAN:
                begin
                    if (scan_issue)
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                    scan_pend_reg <= scan_issue;
                    if (scan_pend_reg)
                    begin
                        run_cut_reg <= run_next;
                        cut_max_reg <= cut_max_next;
                    end
                    if (!scan_issue && !scan_pend_reg)
                    begin
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        out_valid_reg <= 1'b1;
                        out_sum_reg   <= sum_acc_reg;
                        out_cut_reg   <= cut_max_reg[CUT_W-1:0];
                        out_span_reg  <= span_max_reg;
                        sum_acc_reg   <= '0;
                        span_max_reg  <= '0;
                        valid_reg     <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_out.valid             = out_valid_reg;
    assign result_out.squared_span_sum  = out_sum_reg;
    assign result_out.max_cut_weight    = out_cut_reg;
    assign result_out.max_weighted_span = out_span_reg;

    // A word without the last mark frees the input after its three steps
    a_item_turnaround: assert property (@(posedge clk) disable iff (!rst_n)
        (item_in.valid && item_in.ready && !item_in.last_entry) |=> ##3 item_in.ready)
        else $error("entry word did not complete in three steps");

    // A new result word only comes out of the emit step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_out.valid) |-> $past(state_reg == S_EMIT))
        else $error("result word raised outside emit");

    // Store writes stay inside the sites in use
    a_store_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (32'(wr_addr) < 32'(n_act)))
        else $error("crossing store written beyond site count");

    // Each result clears the store for the next matrix
    a_store_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        emit_go |=> (valid_reg == '0))
        else $error("crossing store not cleared after result");

    // Scan reads are folded only while scanning
    a_scan_pending: assert property (@(posedge clk) disable iff (!rst_n)
        scan_pend_reg |-> (state_reg == S_SCAN))
        else $error("scan read pending outside scan");

endmodule : linear_arrangement_cost_metrics_top

### test/tb_linear_arrangement_cost_metrics_top.sv
// ----------------------------------------------------------------------------
// tb_linear_arrangement_cost_metrics_top
// Self-checking bench for the linear arrangement cost block. Matrix entry
// words go in over a valid/ready channel with bursty timing, and the three
// layout costs come back on a stalling result channel. A cost predictor
// folds every accepted entry word under the site count in force, and each
// result word is checked field by field against the oldest prediction.
// Directed matrices cover the field extremes, the triangles, out-of-range
// labels, the site-count limits and a count change part way through a
// matrix. A back-pressure test and random matrices over many site counts
// follow.
// ----------------------------------------------------------------------------
module tb_linear_arrangement_cost_metrics_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lacm_pkg::*;

    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     LONG_HOLD      = 300;
    localparam int     SETTLE_CYCLES  = 12;
    localparam int     RANDOM_ITEMS   = 1200;
    localparam int     RANDOM_RESULTS = 40;
    localparam longint CUT_SAT        = (longint'(1) << CUT_W) - 1;
    localparam longint SPAN_SAT       = (longint'(1) << SPAN_W) - 1;
    localparam logic [CFG_ADDR_W-1:0] SITE_COUNT_ADDR =
        CFG_ADDR_W'(4 * int'(REG_SITE_COUNT));

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic [WT_W-1:0]  weight;
        logic             last;
    } entry_t;

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [CUT_W-1:0]  cut;
        logic [SPAN_W-1:0] span;
    } cost_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    lacm_item_if   item_ch ();
    lacm_result_if cost_ch ();

    linear_arrangement_cost_metrics_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .item_in    (item_ch),
        .result_out (cost_ch)
    );

    // Predictor state: register copy and per-matrix accumulators
    logic [SITE_W-1:0] site_count_cfg;
    longint            sq_span_total;
    longint            span_peak;
    longint            crossing_delta [MAX_SITES];
    cost_t             cost_expect_q [$];

    // Bookkeeping
    int mismatch_count;
    int words_accepted;
    int results_seen;
    int config_writes;
    int idle_cycles;

    // Sender and receiver pacing
    bit sender_bursty;
    int burst_left;
    int holds_asked;
    int holds_served;
    int hold_left;
    int sink_mode;
    int sink_mode_left;

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // Cost predictor
    // ------------------------------------------------------------------------
    function automatic void clear_matrix_state();
        sq_span_total = 0;
        span_peak     = 0;
        foreach (crossing_delta[i])
            crossing_delta[i] = 0;
    endfunction

    // Folds one entry word in; returns 1 with the costs when it closes a matrix
    function automatic bit fold_entry(input entry_t e, output cost_t res);
        int     n;
        int     lo;
        int     hi;
        int     span_len;
        int     l;
        longint wt;
        longint wspan;
        longint running;
        longint cut_peak;
        n   = (int'(site_count_cfg) > MAX_SITES) ? MAX_SITES : int'(site_count_cfg);
        wt  = longint'(e.weight) & ((longint'(1) << WEIGHT_BITS) - 1);
        res = '0;
        if (int'(e.row) < n && int'(e.col) < n && wt != 0)
        begin
            lo       = (e.row < e.col) ? int'(e.row) : int'(e.col);
            hi       = (e.row < e.col) ? int'(e.col) : int'(e.row);
            span_len = hi - lo;
            sq_span_total += wt * span_len * span_len;
            if (sq_span_total > longint'(SUM_MAX))
                sq_span_total = longint'(SUM_MAX);
            // only the upper triangle crosses cuts
            if (e.row < e.col)
            begin
                wspan = wt * span_len;
                if (wspan > SPAN_SAT)
                    wspan = SPAN_SAT;
                if (wspan > span_peak)
                    span_peak = wspan;
                crossing_delta[e.row] += wt;
                crossing_delta[e.col] -= wt;
            end
        end
        if (!e.last)
            return 1'b0;

        // prefix scan over the cuts between neighbouring labels
        running  = 0;
        cut_peak = 0;
        for (l = 0; l + 1 < n; l++)
        begin
            running += crossing_delta[l];
            if (running > cut_peak)
                cut_peak = running;
        end
        res.sum  = SUM_W'(sq_span_total);
        res.cut  = CUT_W'((cut_peak > CUT_SAT) ? CUT_SAT : cut_peak);
        res.span = SPAN_W'(span_peak);
        clear_matrix_state();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Entry word monitor: predicts costs for each accepted word
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : entry_monitor
        entry_t seen;
        cost_t  predicted;
        if (rst_n && item_ch.valid && item_ch.ready)
        begin
            seen.row    = item_ch.row_index;
            seen.col    = item_ch.col_index;
            seen.weight = item_ch.entry_weight;
            seen.last   = item_ch.last_entry;
            words_accepted++;
            if (fold_entry(seen, predicted))
                cost_expect_q.push_back(predicted);
        end
    end

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : cost_checker
        cost_t want;
        if (rst_n && cost_ch.valid && cost_ch.ready)
        begin
            results_seen++;
            if (cost_expect_q.size() == 0)
            begin
                $display("%0t: unexpected cost word sum=%0d cut=%0d span=%0d", $time,
                         cost_ch.squared_span_sum, cost_ch.max_cut_weight,
                         cost_ch.max_weighted_span);
                mismatch_count++;
            end
            else
            begin
                want = cost_expect_q.pop_front();
                if (cost_ch.squared_span_sum !== want.sum)
                begin
                    $display("%0t: squared_span_sum expected %0d got %0d", $time,
                             want.sum, cost_ch.squared_span_sum);
                    mismatch_count++;
                end
                if (cost_ch.max_cut_weight !== want.cut)
                begin
                    $display("%0t: max_cut_weight expected %0d got %0d", $time,
                             want.cut, cost_ch.max_cut_weight);
                    mismatch_count++;
                end
                if (cost_ch.max_weighted_span !== want.span)
                begin
                    $display("%0t: max_weighted_span expected %0d got %0d", $time,
                             want.span, cost_ch.max_weighted_span);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: own stall pattern, plus long hold-offs on request
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin : result_sink
        if (hold_left > 0)
        begin
            hold_left--;
            cost_ch.ready <= 1'b0;
        end
        else if (holds_served < holds_asked)
        begin
            holds_served++;
            hold_left = LONG_HOLD - 1;
            cost_ch.ready <= 1'b0;
        end
        else
        begin
            if (sink_mode_left == 0)
            begin
                sink_mode      = $urandom_range(0, 2);
                sink_mode_left = $urandom_range(8, 60);
            end
            else
                sink_mode_left--;
            case (sink_mode)
                0:       cost_ch.ready <= 1'b1;
                1:       cost_ch.ready <= 1'($urandom_range(0, 1));
                default: cost_ch.ready <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: cycles in a row with no word moving on either channel
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watchdog
        if ((item_ch.valid && item_ch.ready) || (cost_ch.valid && cost_ch.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("linear_arrangement_cost_metrics_top verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Channel and register tasks
    // ------------------------------------------------------------------------
    // Offers one entry word and returns at the edge that accepts it
    task automatic send_entry(input int row, input int col, input int weight,
                              input bit last);
        int gap;
        if (sender_bursty && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            item_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        else if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        item_ch.valid        <= 1'b1;
        item_ch.row_index    <= IDX_W'(row);
        item_ch.col_index    <= IDX_W'(col);
        item_ch.entry_weight <= WT_W'(weight);
        item_ch.last_entry   <= last;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    // Stops offering, waits for every predicted result, then lets the block settle
    task automatic wait_block_idle();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (cost_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_site_count(input logic [SITE_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SITE_COUNT_ADDR;
        pwdata  <= CFG_DATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        site_count_cfg = value;
        config_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_site_count_readback();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= SITE_COUNT_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== CFG_DATA_W'(site_count_cfg))
        begin
            $display("%0t: site_count readback expected %0d got %0d", $time,
                     site_count_cfg, prdata);
            mismatch_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset value, then writes and reads across the whole register range
    task automatic test_register_access();
        check_site_count_readback();
        write_site_count(8'd0);
        check_site_count_readback();
        write_site_count(8'd1);
        check_site_count_readback();
        write_site_count(8'd255);
        check_site_count_readback();
        write_site_count(8'd2);
        check_site_count_readback();
        write_site_count(8'd128);
        check_site_count_readback();
    endtask

    // Field extremes, triangles, diagonal, zero weight and repeats at full size
    task automatic test_directed_entries();
        sender_bursty = 1'b0;
        send_entry(0, 127, 255, 1'b0);     // widest upper span, top weight
        send_entry(127, 0, 255, 1'b0);     // lower triangle: squared sum only
        send_entry(5, 5, 200, 1'b0);       // diagonal adds nothing
        send_entry(20, 90, 0, 1'b0);       // absent entry
        send_entry(3, 10, 7, 1'b0);
        send_entry(3, 10, 7, 1'b0);        // repeated entry accumulates
        send_entry(64, 65, 1, 1'b1);
        // lower triangle only: no cut, no weighted span
        send_entry(100, 1, 170, 1'b0);
        send_entry(127, 127, 85, 1'b1);
        // single upper entry closing its own matrix
        send_entry(0, 1, 1, 1'b1);
        // empty matrix: the last word carries no weight
        send_entry(42, 84, 0, 1'b1);
        wait_block_idle();
    endtask

    // Smallest counts, no sites, and a count above the store size
    task automatic test_site_limits();
        write_site_count(8'd2);
        send_entry(0, 1, 255, 1'b0);
        send_entry(1, 0, 3, 1'b0);
        send_entry(0, 2, 99, 1'b0);        // beyond the count: ignored
        send_entry(127, 1, 50, 1'b1);      // ignored, still closes the matrix
        wait_block_idle();
        write_site_count(8'd1);
        send_entry(0, 0, 9, 1'b0);
        send_entry(0, 1, 9, 1'b1);
        wait_block_idle();
        write_site_count(8'd0);
        send_entry(0, 0, 255, 1'b1);
        wait_block_idle();
        write_site_count(8'd255);          // capped at the store size
        send_entry(0, 127, 128, 1'b0);
        send_entry(126, 127, 255, 1'b1);
        wait_block_idle();
    endtask

    // Site count lowered while a matrix is half loaded
    task automatic test_count_change_mid_matrix();
        write_site_count(8'd128);
        send_entry(10, 100, 50, 1'b0);
        send_entry(0, 3, 9, 1'b0);
        wait_block_idle();
        write_site_count(8'd50);
        send_entry(10, 20, 4, 1'b0);
        send_entry(60, 70, 4, 1'b0);       // now out of range
        send_entry(49, 48, 2, 1'b1);
        wait_block_idle();
        write_site_count(8'd128);
    endtask

    // Receiver holds off while matrices keep coming, so the input side backs up
    task automatic test_result_backpressure();
        int m;
        sender_bursty = 1'b0;
        holds_asked++;
        for (m = 0; m < 3; m++)
        begin
            send_entry(m, 120 - m, 200 + m, 1'b0);
            send_entry(60, 61, 255, 1'b0);
            send_entry(90, 7, 33, 1'b1);
        end
        wait_block_idle();
    endtask

    // Random matrices under changing site counts and pacing
    task automatic test_random_matrices();
        int n_eff;
        int len;
        int k;
        int kind;
        int a;
        int b;
        int t;
        int wt;
        int useful;
        int matrices;
        bit ignored;
        useful   = 0;
        matrices = 0;
        while (useful < RANDOM_ITEMS || matrices < RANDOM_RESULTS)
        begin
            if (matrices % 7 == 0)
            begin
                wait_block_idle();
                case ($urandom_range(0, 5))
                    0:       write_site_count(8'd2);
                    1:       write_site_count(8'd128);
                    2:       write_site_count(8'd200);
                    default: write_site_count(SITE_W'($urandom_range(2, 128)));
                endcase
            end
            n_eff = (int'(site_count_cfg) > MAX_SITES) ? MAX_SITES : int'(site_count_cfg);
            sender_bursty = ($urandom_range(0, 3) != 0);
            len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 24)
                                               : $urandom_range(25, 90);
            for (k = 0; k < len; k++)
            begin
                kind    = $urandom_range(0, 99);
                wt      = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(1, 255);
                a       = $urandom_range(0, n_eff - 1);
                b       = $urandom_range(0, n_eff - 1);
                ignored = 1'b0;
                // mostly upper triangle so the cuts fill up
                if (kind < 70 && a > b)
                begin
                    t = a;
                    a = b;
                    b = t;
                end
                if (kind >= 85 && kind < 93)
                begin
                    wt      = 0;
                    ignored = 1'b1;
                end
                else if (kind >= 93 && n_eff < MAX_SITES)
                begin
                    if ($urandom_range(0, 1) != 0)
                        a = $urandom_range(n_eff, MAX_SITES - 1);
                    else
                        b = $urandom_range(n_eff, MAX_SITES - 1);
                    ignored = 1'b1;
                end
                if (!ignored)
                    useful++;
                send_entry(a, b, wt, k == len - 1);
            end
            matrices++;
        end
        wait_block_idle();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial
    begin
        clk                  = 1'b0;
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        item_ch.valid        = 1'b0;
        item_ch.row_index    = '0;
        item_ch.col_index    = '0;
        item_ch.entry_weight = '0;
        item_ch.last_entry   = 1'b0;
        cost_ch.ready        = 1'b0;
        mismatch_count       = 0;
        words_accepted       = 0;
        results_seen         = 0;
        config_writes        = 0;
        idle_cycles          = 0;
        sender_bursty        = 1'b0;
        burst_left           = 0;
        holds_asked          = 0;
        holds_served         = 0;
        hold_left            = 0;
        sink_mode            = 0;
        sink_mode_left       = 0;
        site_count_cfg       = SITE_COUNT_RST;
        clear_matrix_state();

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_register_access();
        test_directed_entries();
        test_site_limits();
        test_count_change_mid_matrix();
        test_result_backpressure();
        test_random_matrices();

        $display("Covered %0d entry words and %0d cost words over %0d site-count writes,",
                 words_accepted, results_seen, config_writes);
        $display("including site counts 0, 1, 2, 128 and above, and a long result stall.");
        if (mismatch_count == 0)
            $display("linear_arrangement_cost_metrics_top verification clean");
        else
            $display("linear_arrangement_cost_metrics_top verification failed");
        $finish;
    end

endmodule : tb_linear_arrangement_cost_metrics_top
